// File: rtl/isdc_pkg.sv
`timescale 1ns / 1ps

package isdc_pkg;

  typedef enum logic {
    MODE_S2D = 1'b0,
    MODE_D2S = 1'b1
  } mode_e;

  typedef enum logic {
    ST_OK      = 1'b0,
    ST_INVALID = 1'b1
  } status_e;

  // Single precision field layout
  localparam int unsigned SpExpW  = 8;
  localparam int unsigned SpFracW = 23;
  localparam int unsigned SpBias  = 127;
  // Double precision field layout
  localparam int unsigned DpExpW  = 11;
  localparam int unsigned DpFracW = 52;
  localparam int unsigned DpBias  = 1023;

  typedef struct packed {
    logic [63:0] result;
    logic        status;
  } conv_res_t;

endpackage

// File: rtl/ieee_single_double_convert_core.sv
`timescale 1ns / 1ps

// Channel | Direction | Signals
// input   | in        | in_valid_i, in_stall_o, mode_i, value_i
// output  | out       | out_valid_o, out_stall_i, result_o, status_o
//
// One transaction per cycle while the output is not stalled; path: input register, then result register.
// Each item is converted by one pass of logic between the two registers.
// Reset clears only the valid flags; payload registers are not reset.
// A stall on the output holds the result; the input stage still takes a
// transaction while the result register is free or being emptied.
module ieee_single_double_convert_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_o,
  output logic        status_o
);

  logic        a_vld_q, a_vld_d;
  logic        a_mode_q;
  logic [63:0] a_val_q;
  logic        r_vld_q, r_vld_d;
  isdc_pkg::conv_res_t r_q;
  isdc_pkg::conv_res_t s2d_res, d2s_res, sel_res;
  logic        r_load, a_load;

  isdc_s2d u_s2d (.word_i(a_val_q[31:0]), .res_o(s2d_res));
  isdc_d2s u_d2s (.word_i(a_val_q),       .res_o(d2s_res));

  // handshake flow
  always_comb begin
    r_load     = a_vld_q && (!r_vld_q || !out_stall_i);
    a_load     = !a_vld_q || r_load;
    in_stall_o = !a_load;
    a_vld_d    = a_load ? in_valid_i : a_vld_q;
    r_vld_d    = r_load ? 1'b1 : (r_vld_q && out_stall_i);
    sel_res    = (isdc_pkg::mode_e'(a_mode_q) == isdc_pkg::MODE_D2S) ? d2s_res : s2d_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      r_vld_q <= 1'b0;
    end else begin
      a_vld_q <= a_vld_d;
      r_vld_q <= r_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (a_load && in_valid_i) begin
      a_mode_q <= mode_i;
      a_val_q  <= value_i;
    end
    if (r_load) r_q <= sel_res;
  end

  assign out_valid_o = r_vld_q;
  assign result_o    = r_q.result;
  assign status_o    = r_q.status;

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_o))
    else $error("result changed under stall");
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> result_o == 64'd0)
    else $error("invalid status with nonzero result");
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld_q && !out_valid_o |=> out_valid_o)
    else $error("item not advanced");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled without output stall");
`endif

endmodule

// File: rtl/isdc_s2d.sv
`timescale 1ns / 1ps

// Exact single to double widening; infinity and NaN give invalid status
module isdc_s2d (
  input  logic [31:0]          word_i,
  output isdc_pkg::conv_res_t  res_o
);

  logic        sign;
  logic [7:0]  sexp;
  logic [22:0] frac;
  logic [4:0]  lead;
  logic [22:0] norm;
  logic [10:0] dexp;

  // leading one position of a subnormal fraction
  always_comb begin
    lead = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (frac[i]) lead = 5'(i);
    end
  end

  always_comb begin
    sign = word_i[31];
    sexp = word_i[30:23];
    frac = word_i[22:0];
    // drop the leading one and left-align the rest
    norm = 23'(frac << (5'd23 - lead));
    // value is 2^(lead - 149), so biased exponent is lead + 874
    dexp = 11'(11'd874 + 11'(lead));
    res_o.status = isdc_pkg::ST_OK;
    res_o.result = '0;
    if (word_i[30:0] == '0) begin
      res_o.result = {sign, 63'd0};
    end else if (sexp == 8'hff) begin
      res_o.status = isdc_pkg::ST_INVALID;
    end else if (sexp == 8'd0) begin
      res_o.result = {sign, dexp, norm, 29'd0};
    end else begin
      res_o.result = {sign, 11'(11'(sexp) + 11'd896), frac, 29'd0};
    end
  end

endmodule

// File: rtl/isdc_d2s.sv
`timescale 1ns / 1ps

// Double to single narrowing, truncating toward zero; overflow gives infinity, infinity and NaN give invalid status
module isdc_d2s (
  input  logic [63:0]          word_i,
  output isdc_pkg::conv_res_t  res_o
);

  logic        sign;
  logic [10:0] dexp;
  logic [51:0] frac;
  logic [52:0] sig;
  logic [10:0] sh;
  logic [52:0] shifted;

  always_comb begin
    sign = word_i[63];
    dexp = word_i[62:52];
    frac = word_i[51:0];
    sig  = {1'b1, frac};
    // sh = -97 - p = 926 - exponent, only used when exponent < 897
    sh = 11'(11'd926 - dexp);
    shifted = (sh >= 11'd64) ? 53'd0 : (sig >> sh[5:0]);
    res_o.status = isdc_pkg::ST_OK;
    res_o.result = '0;
    if (dexp == 11'd0) begin
      if (frac != '0) res_o.result = {32'd0, sign, 31'd0};
    end else if (dexp == 11'h7ff) begin
      res_o.status = isdc_pkg::ST_INVALID;
    end else if (dexp > 11'd1150) begin
      res_o.result = {32'd0, sign, 8'hff, 23'd0};
    end else if (dexp < 11'd897) begin
      res_o.result = {32'd0, sign, 8'd0, shifted[22:0]};
    end else begin
      res_o.result = {32'd0, sign, 8'(dexp - 11'd896), frac[51:29]};
    end
  end

endmodule
